// ----- src/glyph_quad_vertex_generator_top_defines.svh -----
// Assertion macros for the glyph quad vertex generator.
`ifndef GLYPH_QUAD_VERTEX_GENERATOR_TOP_DEFINES_SVH
`define GLYPH_QUAD_VERTEX_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GQVG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define GQVG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GQVG_ASSERT_IMPLY(label, ante, cons, msg)
`define GQVG_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- src/gqvg_pkg.sv -----
// Shared constants, types and arithmetic helpers for the glyph quad vertex generator.
package gqvg_pkg;

    localparam int GLYPH_COUNT = 256;
    localparam int FRAC_BITS   = 8;
    localparam int IDX_W       = $clog2(GLYPH_COUNT);
    localparam int CORNERS     = 4;

    localparam int CODE_W     = 8;
    localparam int GDIM_W     = 10;
    localparam int BEAR_W     = 11;
    localparam int ATL_W      = 14;
    localparam int ADV_W      = 16;
    localparam int SCALE_W    = 16;
    localparam int ASZ_W      = 15;
    localparam int POS_W      = 24;
    localparam int TEX_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int NUM_W     = ATL_W + 1;
    localparam int DIV_STEPS = TEX_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam int OPND_W  = ADV_W + 1;
    localparam int PROD_W  = OPND_W + SCALE_W + 1;
    localparam int CONV_UP = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
    localparam int CONV_DN = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
    localparam int ADV_SH  = 14 - FRAC_BITS;
    localparam int WIDE_W  = PROD_W + CONV_UP + 2;

    localparam int POS_MAX = 2 ** (POS_W - 1) - 1;
    localparam int POS_MIN = -(2 ** (POS_W - 1));
    localparam logic signed [WIDE_W-1:0] POS_HI_W = WIDE_W'(POS_MAX);
    localparam logic signed [WIDE_W-1:0] POS_LO_W = WIDE_W'(POS_MIN);

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd2;

    localparam int CORNER_RIGHT_BIT  = 1;
    localparam int CORNER_BOTTOM_BIT = 0;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_PLACE   = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CORNER_LT = 2'd0,
        CORNER_LB = 2'd1,
        CORNER_RT = 2'd2,
        CORNER_RB = 2'd3
    } corner_t;

    typedef enum logic [2:0] {
        MUL_LEFT   = 3'd0,
        MUL_RIGHT  = 3'd1,
        MUL_TOP    = 3'd2,
        MUL_BOTTOM = 3'd3,
        MUL_ADV    = 3'd4
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_LEFT_S   = 2'd0,
        DIV_RIGHT_S  = 2'd1,
        DIV_BOTTOM_T = 2'd2,
        DIV_TOP_T    = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic [GDIM_W-1:0]        w;
        logic [GDIM_W-1:0]        h;
        logic signed [BEAR_W-1:0] bx;
        logic signed [BEAR_W-1:0] by;
    } shape_t;

    typedef struct packed {
        logic [ATL_W-1:0] s;
        logic [ATL_W-1:0] t;
        logic [ADV_W-1:0] adv;
    } atlas_ent_t;

    typedef struct packed {
        logic     load_wr;
        logic     place_rd;
        logic     pen_clear;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     emit_load;
        corner_t  emit_corner;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } sts_t;

    function automatic logic [IDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
        logic [IDX_W+CODE_W-1:0] ext;
        ext = {{IDX_W{1'b0}}, code};
        return ext[IDX_W-1:0];
    endfunction

    // 8 fraction bits in, FRAC_BITS out; right shift floors
    function automatic logic signed [WIDE_W-1:0] conv(input logic signed [PROD_W-1:0] p);
        logic signed [WIDE_W-1:0] w;
        w = WIDE_W'(p);
        return (w <<< CONV_UP) >>> CONV_DN;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > POS_HI_W) begin
            r = POS_W'(POS_MAX);
        end else if (v < POS_LO_W) begin
            r = POS_W'(POS_MIN);
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- src/glyph_quad_vertex_generator_top.sv -----
// Top level of the glyph quad vertex generator: sequencer plus datapath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//  s (in)   | s_valid/s_ready     | s_operation, s_char_code, glyph metrics
//  m (out)  | m_valid/m_ready     | m_corner, m_pos_x/y, m_tex_s/t, m_last_corner
//
// Load and restart words are accepted without leaving the idle state. A place word holds
// the input off through one table read, five products on the shared multiplier,
// four 16-step divisions on the shared divider and four corner words; output
// stalls lengthen the emit phase.
// The last corner waits in the output register while the next word is accepted.
// Reset is synchronous, active low; glyph tables are not cleared.
`include "glyph_quad_vertex_generator_top_defines.svh"
module glyph_quad_vertex_generator_top (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [gqvg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [gqvg_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [1:0]                              s_operation,
    input  logic [gqvg_pkg::CODE_W-1:0]             s_char_code,
    input  logic [gqvg_pkg::GDIM_W-1:0]             s_glyph_width,
    input  logic [gqvg_pkg::GDIM_W-1:0]             s_glyph_height,
    input  logic signed [gqvg_pkg::BEAR_W-1:0]      s_bearing_x,
    input  logic signed [gqvg_pkg::BEAR_W-1:0]      s_bearing_y,
    input  logic [gqvg_pkg::ATL_W-1:0]              s_atlas_s,
    input  logic [gqvg_pkg::ATL_W-1:0]              s_atlas_t,
    input  logic [gqvg_pkg::ADV_W-1:0]              s_advance_units,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [1:0]                              m_corner,
    output logic signed [gqvg_pkg::POS_W-1:0]       m_pos_x,
    output logic signed [gqvg_pkg::POS_W-1:0]       m_pos_y,
    output logic [gqvg_pkg::TEX_W-1:0]              m_tex_s,
    output logic [gqvg_pkg::TEX_W-1:0]              m_tex_t,
    output logic                                    m_last_corner
);

    gqvg_pkg::cmd_t cmd;
    gqvg_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    gqvg_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .sts         (sts),
        .s_ready     (s_ready),
        .cmd         (cmd)
    );

    gqvg_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_wr          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_char_code     (s_char_code),
        .s_glyph_width   (s_glyph_width),
        .s_glyph_height  (s_glyph_height),
        .s_bearing_x     (s_bearing_x),
        .s_bearing_y     (s_bearing_y),
        .s_atlas_s       (s_atlas_s),
        .s_atlas_t       (s_atlas_t),
        .s_advance_units (s_advance_units),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_corner        (m_corner),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_tex_s         (m_tex_s),
        .m_tex_t         (m_tex_t),
        .m_last_corner   (m_last_corner)
    );

    `GQVG_ASSERT_IMPLY(a_idle_only_last_pending, s_ready && m_valid, m_last_corner, "input ready while corners of a character are pending")
    `GQVG_ASSERT_NEXT(a_corners_back_to_back, m_valid && m_ready && !m_last_corner, m_valid, "gap between corners of one character")
    `GQVG_ASSERT_NEXT(a_corner_order, m_valid && m_ready && !m_last_corner, m_corner == 2'($past(m_corner) + 2'd1), "corners out of order")
    `GQVG_ASSERT_NEXT(a_place_busy, s_valid && s_ready && s_operation == gqvg_pkg::OP_PLACE, !s_ready, "input still ready after a place word")

endmodule

// ----- src/gqvg_div.sv -----
// Radix-2 restoring divider producing a saturated Q0.16 ratio num/den.
module gqvg_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [gqvg_pkg::NUM_W-1:0] num,
    input  logic [gqvg_pkg::ASZ_W-1:0] den,
    output logic                       done,
    output logic [gqvg_pkg::TEX_W-1:0] quot
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [gqvg_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic [gqvg_pkg::ASZ_W-1:0]  rem_reg, rem_next;
    logic [gqvg_pkg::ASZ_W-1:0]  den_reg, den_next;
    logic [gqvg_pkg::TEX_W-1:0]  quo_reg, quo_next;
    logic                        sat_reg, sat_next;
    logic [gqvg_pkg::ASZ_W:0]    rem_sh;
    logic                        ge;

    assign rem_sh = {rem_reg, 1'b0};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        sat_next  = sat_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = gqvg_pkg::DCNT_W'(gqvg_pkg::DIV_STEPS);
            rem_next  = gqvg_pkg::ASZ_W'(num);
            den_next  = den;
            quo_next  = '0;
            // quotient reaches 1.0 or den is zero
            sat_next  = num >= gqvg_pkg::NUM_W'(den);
        end else if (busy_reg) begin
            rem_next = ge ? gqvg_pkg::ASZ_W'(rem_sh - {1'b0, den_reg}) : rem_sh[gqvg_pkg::ASZ_W-1:0];
            quo_next = {quo_reg[gqvg_pkg::TEX_W-2:0], ge};
            cnt_next = cnt_reg - gqvg_pkg::DCNT_W'(1);
            if (cnt_reg == gqvg_pkg::DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        sat_reg <= sat_next;
    end

    assign done = done_reg;
    assign quot = sat_reg ? {gqvg_pkg::TEX_W{1'b1}} : quo_reg;

endmodule

// ----- src/gqvg_ctrl.sv -----
// Sequencer: accepts words, steps multiplies, divisions and corner emission.
module gqvg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [1:0]        s_operation,
    input  gqvg_pkg::sts_t    sts,
    output logic              s_ready,
    output gqvg_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_READ     = 6'b000010,
        ST_MUL      = 6'b000100,
        ST_DIV_GO   = 6'b001000,
        ST_DIV_WAIT = 6'b010000,
        ST_EMIT     = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    gqvg_pkg::mul_sel_t mul_sel_reg, mul_sel_next;
    gqvg_pkg::div_sel_t div_sel_reg, div_sel_next;
    gqvg_pkg::corner_t  corner_reg, corner_next;
    logic               accept;

    assign s_ready = state_reg == ST_IDLE;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        mul_sel_next = mul_sel_reg;
        div_sel_next = div_sel_reg;
        corner_next  = corner_reg;
        cmd             = '0;
        cmd.load_wr     = accept && s_operation == gqvg_pkg::OP_LOAD;
        cmd.place_rd    = accept && s_operation == gqvg_pkg::OP_PLACE;
        cmd.pen_clear   = accept && s_operation == gqvg_pkg::OP_RESTART;
        cmd.mul_sel     = mul_sel_reg;
        cmd.div_sel     = div_sel_reg;
        cmd.emit_corner = corner_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.place_rd) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                mul_sel_next = gqvg_pkg::MUL_LEFT;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                if (mul_sel_reg == gqvg_pkg::MUL_ADV) begin
                    div_sel_next = gqvg_pkg::DIV_LEFT_S;
                    state_next   = ST_DIV_GO;
                end else begin
                    mul_sel_next = gqvg_pkg::mul_sel_t'(mul_sel_reg + 3'd1);
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    if (div_sel_reg == gqvg_pkg::DIV_TOP_T) begin
                        corner_next = gqvg_pkg::CORNER_LT;
                        state_next  = ST_EMIT;
                    end else begin
                        div_sel_next = gqvg_pkg::div_sel_t'(div_sel_reg + 2'd1);
                        state_next   = ST_DIV_GO;
                    end
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (corner_reg == gqvg_pkg::CORNER_RB) begin
                        state_next = ST_IDLE;
                    end else begin
                        corner_next = gqvg_pkg::corner_t'(corner_reg + 2'd1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mul_sel_reg <= gqvg_pkg::MUL_LEFT;
            div_sel_reg <= gqvg_pkg::DIV_LEFT_S;
            corner_reg  <= gqvg_pkg::CORNER_LT;
        end else begin
            state_reg   <= state_next;
            mul_sel_reg <= mul_sel_next;
            div_sel_reg <= div_sel_next;
            corner_reg  <= corner_next;
        end
    end

endmodule

// ----- src/gqvg_dpath.sv -----
// Datapath: glyph tables, config registers, shared multiplier, divider, pen and output word.
module gqvg_dpath (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  gqvg_pkg::cmd_t                          cmd,
    output gqvg_pkg::sts_t                          sts,
    input  logic                                    cfg_wr,
    input  logic [gqvg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [gqvg_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic [gqvg_pkg::CODE_W-1:0]             s_char_code,
    input  logic [gqvg_pkg::GDIM_W-1:0]             s_glyph_width,
    input  logic [gqvg_pkg::GDIM_W-1:0]             s_glyph_height,
    input  logic signed [gqvg_pkg::BEAR_W-1:0]      s_bearing_x,
    input  logic signed [gqvg_pkg::BEAR_W-1:0]      s_bearing_y,
    input  logic [gqvg_pkg::ATL_W-1:0]              s_atlas_s,
    input  logic [gqvg_pkg::ATL_W-1:0]              s_atlas_t,
    input  logic [gqvg_pkg::ADV_W-1:0]              s_advance_units,
    input  logic                                    m_ready,
    output logic                                    m_valid,
    output logic [1:0]                              m_corner,
    output logic signed [gqvg_pkg::POS_W-1:0]       m_pos_x,
    output logic signed [gqvg_pkg::POS_W-1:0]       m_pos_y,
    output logic [gqvg_pkg::TEX_W-1:0]              m_tex_s,
    output logic [gqvg_pkg::TEX_W-1:0]              m_tex_t,
    output logic                                    m_last_corner
);

    // config
    logic [gqvg_pkg::SCALE_W-1:0] scale_reg;
    logic [gqvg_pkg::ASZ_W-1:0]   atlas_w_reg, atlas_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg   <= gqvg_pkg::SCALE_W'(256);
            atlas_w_reg <= gqvg_pkg::ASZ_W'(256);
            atlas_h_reg <= gqvg_pkg::ASZ_W'(256);
        end else if (cfg_wr) begin
            unique case (cfg_index)
                gqvg_pkg::CFG_SIZE_SCALE:   scale_reg   <= cfg_data;
                gqvg_pkg::CFG_ATLAS_WIDTH:  atlas_w_reg <= cfg_data[gqvg_pkg::ASZ_W-1:0];
                gqvg_pkg::CFG_ATLAS_HEIGHT: atlas_h_reg <= cfg_data[gqvg_pkg::ASZ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // glyph tables
    gqvg_pkg::shape_t     shape_mem_reg [gqvg_pkg::GLYPH_COUNT];
    gqvg_pkg::atlas_ent_t atlas_mem_reg [gqvg_pkg::GLYPH_COUNT];
    gqvg_pkg::shape_t     shape_rd_reg;
    gqvg_pkg::atlas_ent_t atlas_rd_reg;
    logic [gqvg_pkg::IDX_W-1:0] idx;

    assign idx = gqvg_pkg::glyph_index(s_char_code);

    always_ff @(posedge aclk) begin
        if (cmd.load_wr) begin
            shape_mem_reg[idx] <= '{w: s_glyph_width, h: s_glyph_height,
                                    bx: s_bearing_x, by: s_bearing_y};
            atlas_mem_reg[idx] <= '{s: s_atlas_s, t: s_atlas_t, adv: s_advance_units};
        end
        if (cmd.place_rd) begin
            shape_rd_reg <= shape_mem_reg[idx];
            atlas_rd_reg <= atlas_mem_reg[idx];
        end
    end

    // shared multiplier, one product per cycle
    logic signed [gqvg_pkg::OPND_W-1:0]  opnd, bx_e, by_e, w_e, h_e;
    logic signed [gqvg_pkg::SCALE_W:0]   scale_s;
    logic signed [gqvg_pkg::PROD_W-1:0]  prod_next, prod_reg;
    gqvg_pkg::mul_sel_t                  prod_sel_reg;
    logic                                prod_vld_reg;

    assign bx_e    = gqvg_pkg::OPND_W'(shape_rd_reg.bx);
    assign by_e    = gqvg_pkg::OPND_W'(shape_rd_reg.by);
    assign w_e     = signed'(gqvg_pkg::OPND_W'(shape_rd_reg.w));
    assign h_e     = signed'(gqvg_pkg::OPND_W'(shape_rd_reg.h));
    assign scale_s = signed'({1'b0, scale_reg});

    always_comb begin
        unique case (cmd.mul_sel)
            gqvg_pkg::MUL_LEFT:   opnd = bx_e;
            gqvg_pkg::MUL_RIGHT:  opnd = bx_e + w_e;
            gqvg_pkg::MUL_TOP:    opnd = by_e;
            gqvg_pkg::MUL_BOTTOM: opnd = by_e - h_e;
            gqvg_pkg::MUL_ADV:    opnd = signed'(gqvg_pkg::OPND_W'(atlas_rd_reg.adv));
            default:              opnd = '0;
        endcase
    end

    assign prod_next = opnd * scale_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        prod_sel_reg <= cmd.mul_sel;
    end

    // scale, place and saturate the registered product
    logic signed [gqvg_pkg::POS_W-1:0]  pen_reg, pen_next;
    logic signed [gqvg_pkg::POS_W-1:0]  left_x_reg, right_x_reg, top_y_reg, bot_y_reg;
    logic signed [gqvg_pkg::WIDE_W-1:0] conv_v, pen_w, adv_w, x_pos, y_pos;

    assign conv_v = gqvg_pkg::conv(prod_reg);
    assign pen_w  = gqvg_pkg::WIDE_W'(pen_reg);
    assign adv_w  = gqvg_pkg::WIDE_W'(prod_reg >>> gqvg_pkg::ADV_SH);
    assign x_pos  = pen_w + conv_v;
    assign y_pos  = conv_v;

    always_comb begin
        pen_next = pen_reg;
        if (cmd.pen_clear) begin
            pen_next = '0;
        end else if (prod_vld_reg && prod_sel_reg == gqvg_pkg::MUL_ADV) begin
            pen_next = gqvg_pkg::sat_pos(pen_w + adv_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_reg <= '0;
        end else begin
            pen_reg <= pen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_vld_reg) begin
            unique case (prod_sel_reg)
                gqvg_pkg::MUL_LEFT:   left_x_reg  <= gqvg_pkg::sat_pos(x_pos);
                gqvg_pkg::MUL_RIGHT:  right_x_reg <= gqvg_pkg::sat_pos(x_pos);
                gqvg_pkg::MUL_TOP:    top_y_reg   <= gqvg_pkg::sat_pos(y_pos);
                gqvg_pkg::MUL_BOTTOM: bot_y_reg   <= gqvg_pkg::sat_pos(y_pos);
                default: begin
                end
            endcase
        end
    end

    // atlas coordinates through the shared divider
    logic [gqvg_pkg::NUM_W-1:0] div_num;
    logic [gqvg_pkg::ASZ_W-1:0] div_den;
    logic [gqvg_pkg::TEX_W-1:0] div_quot;
    logic                       div_done;
    logic [gqvg_pkg::TEX_W-1:0] left_s_reg, right_s_reg, bot_t_reg, top_t_reg;

    always_comb begin
        unique case (cmd.div_sel)
            gqvg_pkg::DIV_LEFT_S: begin
                div_num = gqvg_pkg::NUM_W'(atlas_rd_reg.s);
                div_den = atlas_w_reg;
            end
            gqvg_pkg::DIV_RIGHT_S: begin
                div_num = gqvg_pkg::NUM_W'(atlas_rd_reg.s) + gqvg_pkg::NUM_W'(shape_rd_reg.w);
                div_den = atlas_w_reg;
            end
            gqvg_pkg::DIV_BOTTOM_T: begin
                div_num = gqvg_pkg::NUM_W'(atlas_rd_reg.t);
                div_den = atlas_h_reg;
            end
            gqvg_pkg::DIV_TOP_T: begin
                div_num = gqvg_pkg::NUM_W'(atlas_rd_reg.t) + gqvg_pkg::NUM_W'(shape_rd_reg.h);
                div_den = atlas_h_reg;
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    gqvg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (div_done) begin
            unique case (cmd.div_sel)
                gqvg_pkg::DIV_LEFT_S:   left_s_reg  <= div_quot;
                gqvg_pkg::DIV_RIGHT_S:  right_s_reg <= div_quot;
                gqvg_pkg::DIV_BOTTOM_T: bot_t_reg   <= div_quot;
                gqvg_pkg::DIV_TOP_T:    top_t_reg   <= div_quot;
                default: begin
                end
            endcase
        end
    end

    // output word register
    logic                              m_valid_reg;
    logic [1:0]                        m_corner_reg;
    logic signed [gqvg_pkg::POS_W-1:0] m_pos_x_reg, m_pos_y_reg;
    logic [gqvg_pkg::TEX_W-1:0]        m_tex_s_reg, m_tex_t_reg;
    logic                              m_last_reg;
    logic                              is_right, is_bottom;

    assign is_right  = cmd.emit_corner[gqvg_pkg::CORNER_RIGHT_BIT];
    assign is_bottom = cmd.emit_corner[gqvg_pkg::CORNER_BOTTOM_BIT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            m_corner_reg <= cmd.emit_corner;
            m_pos_x_reg  <= is_right  ? right_x_reg : left_x_reg;
            m_pos_y_reg  <= is_bottom ? bot_y_reg   : top_y_reg;
            m_tex_s_reg  <= is_right  ? right_s_reg : left_s_reg;
            m_tex_t_reg  <= is_bottom ? top_t_reg   : bot_t_reg;
            m_last_reg   <= cmd.emit_corner == gqvg_pkg::CORNER_RB;
        end
    end

    assign sts.div_done  = div_done;
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_corner      = m_corner_reg;
    assign m_pos_x       = m_pos_x_reg;
    assign m_pos_y       = m_pos_y_reg;
    assign m_tex_s       = m_tex_s_reg;
    assign m_tex_t       = m_tex_t_reg;
    assign m_last_corner = m_last_reg;

endmodule

// ----- tb/sv/glyph_quad_vertex_checker.sv -----
// Checker for the glyph quad vertex generator: mirrors glyph state and compares corner words.
module glyph_quad_vertex_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [gqvg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gqvg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic [gqvg_pkg::CODE_W-1:0]         s_char_code,
    input  logic [gqvg_pkg::GDIM_W-1:0]         s_glyph_width,
    input  logic [gqvg_pkg::GDIM_W-1:0]         s_glyph_height,
    input  logic signed [gqvg_pkg::BEAR_W-1:0]  s_bearing_x,
    input  logic signed [gqvg_pkg::BEAR_W-1:0]  s_bearing_y,
    input  logic [gqvg_pkg::ATL_W-1:0]          s_atlas_s,
    input  logic [gqvg_pkg::ATL_W-1:0]          s_atlas_t,
    input  logic [gqvg_pkg::ADV_W-1:0]          s_advance_units,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [1:0]                          m_corner,
    input  logic signed [gqvg_pkg::POS_W-1:0]   m_pos_x,
    input  logic signed [gqvg_pkg::POS_W-1:0]   m_pos_y,
    input  logic [gqvg_pkg::TEX_W-1:0]          m_tex_s,
    input  logic [gqvg_pkg::TEX_W-1:0]          m_tex_t,
    input  logic                                m_last_corner,
    output int                                  mismatch_count,
    output int                                  pending_count
);
    import gqvg_pkg::*;

    localparam int SH_UP = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
    localparam int SH_DN = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
    localparam longint POS_HI = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint POS_LO = -(longint'(1) <<< (POS_W - 1));

    typedef struct {
        corner_t                  corner;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [TEX_W-1:0]         tex_s;
        logic [TEX_W-1:0]         tex_t;
        logic                     last;
    } vertex_t;

    logic [SCALE_W-1:0] scale_q;
    logic [ASZ_W-1:0]   width_q;
    logic [ASZ_W-1:0]   height_q;
    shape_t             shapes [GLYPH_COUNT];
    atlas_ent_t         atlas_q [GLYPH_COUNT];
    longint             pen_q;
    vertex_t            pending_vertices [$];
    int                 mismatches;

    // 8 fraction bits to FRAC_BITS, floor on the way down
    function automatic longint to_frac(input longint p);
        return (p <<< SH_UP) >>> SH_DN;
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_HI) return POS_HI;
        if (v < POS_LO) return POS_LO;
        return v;
    endfunction

    function automatic logic [TEX_W-1:0] tex_ratio(input longint num, input longint den);
        longint q;
        if (den == 0) return {TEX_W{1'b1}};
        q = (num <<< 16) / den;
        if (q > 65535) return {TEX_W{1'b1}};
        return q[TEX_W-1:0];
    endfunction

    function automatic void place_glyph(input int idx);
        shape_t           g;
        atlas_ent_t       a;
        longint           sc, bx, by, gw, gh, as_, at_, au, aw, ah, adv;
        longint           xs [2];
        longint           ys [2];
        logic [TEX_W-1:0] ss [2];
        logic [TEX_W-1:0] ts [2];
        vertex_t          v;
        logic [1:0]       kk;
        g   = shapes[idx];
        a   = atlas_q[idx];
        sc  = scale_q;
        bx  = $signed(g.bx);
        by  = $signed(g.by);
        gw  = g.w;
        gh  = g.h;
        as_ = a.s;
        at_ = a.t;
        au  = a.adv;
        aw  = width_q;
        ah  = height_q;
        xs[0] = clamp_pos(pen_q + to_frac(bx * sc));
        xs[1] = clamp_pos(pen_q + to_frac((bx + gw) * sc));
        ys[0] = clamp_pos(to_frac(by * sc));
        ys[1] = clamp_pos(to_frac((by - gh) * sc));
        ss[0] = tex_ratio(as_, aw);
        ss[1] = tex_ratio(as_ + gw, aw);
        ts[0] = tex_ratio(at_, ah);
        ts[1] = tex_ratio(at_ + gh, ah);
        for (int k = 0; k < CORNERS; k++) begin
            kk       = k[1:0];
            v.corner = corner_t'(kk);
            v.pos_x  = xs[kk[CORNER_RIGHT_BIT]][POS_W-1:0];
            v.pos_y  = ys[kk[CORNER_BOTTOM_BIT]][POS_W-1:0];
            v.tex_s  = ss[kk[CORNER_RIGHT_BIT]];
            v.tex_t  = ts[kk[CORNER_BOTTOM_BIT]];
            v.last   = (v.corner == CORNER_RB);
            pending_vertices.push_back(v);
        end
        adv   = (au * sc) >>> (14 - FRAC_BITS);
        pen_q = clamp_pos(pen_q + adv);
    endfunction

    always @(posedge aclk) begin
        vertex_t want;
        int      idx;
        if (!aresetn) begin
            scale_q    = 16'd256;
            width_q    = 15'd256;
            height_q   = 15'd256;
            pen_q      = 0;
            mismatches = 0;
            pending_vertices.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SIZE_SCALE:   scale_q  = cfg_data[SCALE_W-1:0];
                    CFG_ATLAS_WIDTH:  width_q  = cfg_data[ASZ_W-1:0];
                    CFG_ATLAS_HEIGHT: height_q = cfg_data[ASZ_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                idx = int'(s_char_code) % GLYPH_COUNT;
                case (s_operation)
                    OP_LOAD: begin
                        shapes[idx].w    = s_glyph_width;
                        shapes[idx].h    = s_glyph_height;
                        shapes[idx].bx   = s_bearing_x;
                        shapes[idx].by   = s_bearing_y;
                        atlas_q[idx].s   = s_atlas_s;
                        atlas_q[idx].t   = s_atlas_t;
                        atlas_q[idx].adv = s_advance_units;
                    end
                    OP_PLACE:   place_glyph(idx);
                    OP_RESTART: pen_q = 0;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_vertices.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"unpredicted corner word: ",
                                  "corner %0d x %0d y %0d s %0d t %0d last %0d"},
                                 m_corner, m_pos_x, m_pos_y, m_tex_s, m_tex_t, m_last_corner);
                    end
                end else begin
                    want = pending_vertices.pop_front();
                    if (m_corner !== want.corner || m_pos_x !== want.pos_x
                            || m_pos_y !== want.pos_y || m_tex_s !== want.tex_s
                            || m_tex_t !== want.tex_t || m_last_corner !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("corner word mismatch at %0t", $realtime);
                            $display("  want corner %0d x %0d y %0d s %0d t %0d last %0d",
                                     want.corner, want.pos_x, want.pos_y, want.tex_s,
                                     want.tex_t, want.last);
                            $display("  got  corner %0d x %0d y %0d s %0d t %0d last %0d",
                                     m_corner, m_pos_x, m_pos_y, m_tex_s, m_tex_t,
                                     m_last_corner);
                        end
                    end
                end
            end
        end
        mismatch_count <= mismatches;
        pending_count  <= pending_vertices.size();
    end

endmodule

// ----- tb/sv/glyph_quad_vertex_generator_top_test.sv -----
// Testbench top for the glyph quad vertex generator: stimulus, idling and verdict.
module glyph_quad_vertex_generator_top_test;
    import gqvg_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 100;
    localparam int QUIET_LIMIT   = 4000;

    typedef struct {
        logic [1:0]               op;
        logic [CODE_W-1:0]        code;
        logic [GDIM_W-1:0]        w;
        logic [GDIM_W-1:0]        h;
        logic signed [BEAR_W-1:0] bx;
        logic signed [BEAR_W-1:0] by;
        logic [ATL_W-1:0]         s;
        logic [ATL_W-1:0]         t;
        logic [ADV_W-1:0]         adv;
    } glyph_word_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_operation;
    logic [CODE_W-1:0]        s_char_code;
    logic [GDIM_W-1:0]        s_glyph_width;
    logic [GDIM_W-1:0]        s_glyph_height;
    logic signed [BEAR_W-1:0] s_bearing_x;
    logic signed [BEAR_W-1:0] s_bearing_y;
    logic [ATL_W-1:0]         s_atlas_s;
    logic [ATL_W-1:0]         s_atlas_t;
    logic [ADV_W-1:0]         s_advance_units;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [1:0]               m_corner;
    logic signed [POS_W-1:0]  m_pos_x;
    logic signed [POS_W-1:0]  m_pos_y;
    logic [TEX_W-1:0]         m_tex_s;
    logic [TEX_W-1:0]         m_tex_t;
    logic                     m_last_corner;

    int mismatch_count;
    int pending_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    bit loaded_map [GLYPH_COUNT];
    int loaded_codes [$];

    glyph_quad_vertex_generator_top dut (.*);

    glyph_quad_vertex_checker u_checker (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input glyph_word_t w);
        int idx;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= w.op;
        s_char_code     <= w.code;
        s_glyph_width   <= w.w;
        s_glyph_height  <= w.h;
        s_bearing_x     <= w.bx;
        s_bearing_y     <= w.by;
        s_atlas_s       <= w.s;
        s_atlas_t       <= w.t;
        s_advance_units <= w.adv;
        do @(posedge aclk); while (!s_ready);
        idx = int'(w.code) % GLYPH_COUNT;
        if (w.op == OP_LOAD && !loaded_map[idx]) begin
            loaded_map[idx] = 1'b1;
            loaded_codes.push_back(idx);
        end
    endtask

    function automatic glyph_word_t noise_word();
        glyph_word_t w;
        w.op   = OP_LOAD;
        w.code = CODE_W'($urandom);
        w.w    = GDIM_W'($urandom);
        w.h    = GDIM_W'($urandom);
        w.bx   = BEAR_W'($urandom);
        w.by   = BEAR_W'($urandom);
        w.s    = ATL_W'($urandom);
        w.t    = ATL_W'($urandom);
        w.adv  = ADV_W'($urandom);
        return w;
    endfunction

    function automatic glyph_word_t random_word();
        glyph_word_t w;
        int          roll;
        w    = noise_word();
        roll = $urandom_range(99);
        if (roll < 25 || loaded_codes.size() == 0) begin
            w.op = OP_LOAD;
        end else if (roll < 85) begin
            w.op   = OP_PLACE;
            w.code = CODE_W'(loaded_codes[$urandom_range(loaded_codes.size() - 1)]);
        end else if (roll < 93) begin
            w.op = OP_RESTART;
        end else begin
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    task automatic send_load(input logic [CODE_W-1:0] code, input logic [GDIM_W-1:0] gw,
                             input logic [GDIM_W-1:0] gh, input logic signed [BEAR_W-1:0] bx,
                             input logic signed [BEAR_W-1:0] by, input logic [ATL_W-1:0] as_,
                             input logic [ATL_W-1:0] at_, input logic [ADV_W-1:0] adv);
        glyph_word_t w;
        w.op   = OP_LOAD;
        w.code = code;
        w.w    = gw;
        w.h    = gh;
        w.bx   = bx;
        w.by   = by;
        w.s    = as_;
        w.t    = at_;
        w.adv  = adv;
        send_word(w);
    endtask

    // fields other than op and code carry noise
    task automatic send_cmd(input logic [1:0] op, input logic [CODE_W-1:0] code);
        glyph_word_t w;
        w      = noise_word();
        w.op   = op;
        w.code = code;
        send_word(w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] scale,
                             input logic [CFG_DATA_W-1:0] aw,
                             input logic [CFG_DATA_W-1:0] ah);
        write_reg(CFG_SIZE_SCALE, scale);
        write_reg(CFG_ATLAS_WIDTH, aw);
        write_reg(CFG_ATLAS_HEIGHT, ah);
        cfg_valid <= 1'b0;
    endtask

    // drain all corner words, then give load/restart words time to retire
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] scale, input logic [CFG_DATA_W-1:0] aw,
                             input logic [CFG_DATA_W-1:0] ah, input int count,
                             input int idle_pct, input int stall_pct);
        glyph_word_t w;
        int          n;
        settle();
        configure(scale, aw, ah);
        send_idle_pct  = idle_pct;
        recv_stall_pct <= stall_pct;
        n = 0;
        while (n < count) begin
            w = random_word();
            send_word(w);
            if (w.op != OP_UNUSED) n++;
        end
    endtask

    initial begin
        aresetn         <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= CFG_SIZE_SCALE;
        cfg_data        <= '0;
        s_valid         <= 1'b0;
        s_operation     <= OP_LOAD;
        s_char_code     <= '0;
        s_glyph_width   <= '0;
        s_glyph_height  <= '0;
        s_bearing_x     <= '0;
        s_bearing_y     <= '0;
        s_atlas_s       <= '0;
        s_atlas_t       <= '0;
        s_advance_units <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        configure(16'd256, 16'd256, 16'd256);
        send_load(8'd0, 10'd0, 10'd0, 11'sd0, 11'sd0, 14'd0, 14'd0, 16'd0);
        send_cmd(OP_PLACE, 8'd0);
        send_load(8'd255, 10'd1023, 10'd1023, 11'sd1023, 11'sd1023, 14'd16383, 14'd16383,
                  16'hFFFF);
        send_cmd(OP_PLACE, 8'd255);
        send_cmd(OP_PLACE, 8'd255);
        send_load(8'd1, 10'd1023, 10'd0, -11'sd1024, -11'sd1024, 14'd100, 14'd200, 16'd64);
        send_cmd(OP_PLACE, 8'd1);
        send_cmd(OP_RESTART, 8'd0);
        send_cmd(OP_PLACE, 8'd1);
        send_cmd(OP_UNUSED, 8'd1);
        send_cmd(OP_PLACE, 8'd1);
        send_load(8'd128, 10'd17, 10'd23, -11'sd1, 11'sd5, 14'd240, 14'd250, 16'd700);
        send_cmd(OP_PLACE, 8'd128);
        // overwrite of a live entry
        send_load(8'd128, 10'd512, 10'd1, 11'sd511, -11'sd3, 14'd8191, 14'd255, 16'h8000);
        send_cmd(OP_PLACE, 8'd128);
        send_load(8'd170, 10'h2AA, 10'h155, 11'sh2AA, -11'sd342, 14'h2AAA, 14'h1555, 16'hAAAA);
        send_cmd(OP_PLACE, 8'd170);
        send_cmd(OP_PLACE, 8'd0);

        run_phase(16'hFFFF, 16'd1, 16'd16384, 110, 0, 0);
        // zero atlas sizes and zero scale
        run_phase(16'd0, 16'd0, 16'd0, 30, 66, 0);
        run_phase(16'($urandom_range(1, 2048)), 16'($urandom_range(1, 16384)),
                  16'($urandom_range(1, 16384)), 100, 0, 66);
        run_phase(16'($urandom_range(1, 2048)), 16'($urandom_range(1, 16384)),
                  16'($urandom_range(1, 16384)), 100, 30, 30);
        run_phase(16'd1, 16'd16384, 16'd1, 70, 0, 0);

        settle();
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/gqvg_pkg.sv
src/gqvg_div.sv
src/gqvg_ctrl.sv
src/gqvg_dpath.sv
src/glyph_quad_vertex_generator_top.sv
tb/sv/glyph_quad_vertex_checker.sv
tb/sv/glyph_quad_vertex_generator_top_test.sv
